[rtl/ssr_pkg.sv]
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants of the stream search/replace unit
// Byte width, config register indexes and the emit job descriptor.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;   // length registers and fill counter
	localparam int CNT_W     = 4;   // results per request, up to eight
	localparam int MATCH_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REP_LEN   = 2'd3;

	// descriptor of the results caused by one input request
	typedef struct packed {
		logic [CNT_W-1:0]   cnt;     // results still to send
		logic               last;    // final request of the stream
		logic               marker;  // bare end marker, no data byte
		logic [MATCH_W-1:0] mc;      // match count reported with each result
	} job_t;

endpackage

[rtl/ssr_win_cell.sv]
// ----------------------------------------------------------------------------
// ssr_win_cell: one byte cell of the hold window chain
// Takes the byte of its upstream neighbor on each accepted request and
// compares that byte against its aligned pattern byte.
// ----------------------------------------------------------------------------
module ssr_win_cell (
	input  logic                       clk,
	input  logic                       shift,
	input  logic [ssr_pkg::BYTE_W-1:0] d,
	input  logic [ssr_pkg::BYTE_W-1:0] pat_byte,
	output logic [ssr_pkg::BYTE_W-1:0] q,
	output logic                       eq
);

	logic [ssr_pkg::BYTE_W-1:0] byte_q;

	// window byte moves one place down the chain per request
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

	assign eq = (d == pat_byte);
	assign q  = byte_q;

endmodule

[rtl/ssr_emit_cell.sv]
// ----------------------------------------------------------------------------
// ssr_emit_cell: one slot of the result emit chain
// Loads a job byte in parallel, then hands it toward slot zero one per pop.
// ----------------------------------------------------------------------------
module ssr_emit_cell (
	input  logic                       clk,
	input  logic                       load,
	input  logic [ssr_pkg::BYTE_W-1:0] load_byte,
	input  logic                       shift,
	input  logic [ssr_pkg::BYTE_W-1:0] shift_byte,
	output logic [ssr_pkg::BYTE_W-1:0] q
);

	logic [ssr_pkg::BYTE_W-1:0] byte_q;

	// a new job overrides the shift of the finishing one
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= load_byte;
		end else if (shift) begin
			byte_q <= shift_byte;
		end
	end

	assign q = byte_q;

endmodule

[rtl/stream_search_replace_unit.sv]
// ----------------------------------------------------------------------------
// stream_search_replace_unit: streaming byte search and replace
// Window chain matches the pattern, emit chain serializes the results.
// ----------------------------------------------------------------------------
// Accepted requests load the emit chain; each pop registers a result for output.
// Throughput: one byte per cycle while each request yields at most one result
//   and res_stall is low; k results hold the emit chain until all are popped.
// The rate is set by the single emit chain feeding one output register.
// Reset: asynchronous; empties window, emit chain and output, restores the
//   register defaults (pattern length one, empty replacement).
// ----------------------------------------------------------------------------
module stream_search_replace_unit #(
	parameter int MAX_LEN = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_write,
	input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssr_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ssr_pkg::BYTE_W-1:0]    in_byte,
	input  logic                          in_last,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [ssr_pkg::BYTE_W-1:0]    out_byte,
	output logic                          out_valid,
	output logic                          out_last,
	output logic [ssr_pkg::MATCH_W-1:0]   match_count
);

	localparam int LEN_LIMIT = (MAX_LEN < 8) ? MAX_LEN : 8;
	localparam logic [ssr_pkg::LEN_W-1:0] LIM = ssr_pkg::LEN_W'(LEN_LIMIT);

	// configuration registers
	logic [7:0][ssr_pkg::BYTE_W-1:0] cfg_pat_q;
	logic [7:0][ssr_pkg::BYTE_W-1:0] cfg_rep_q;
	logic [ssr_pkg::LEN_W-1:0]       cfg_plen_q;
	logic [ssr_pkg::LEN_W-1:0]       cfg_rlen_q;

	// window and stream state
	logic [ssr_pkg::LEN_W-1:0]   win_fill_q;
	logic [ssr_pkg::MATCH_W-1:0] matches_q;

	// emit chain and output register
	ssr_pkg::job_t               em_job_q;
	logic [ssr_pkg::BYTE_W-1:0]  res_byte_q;
	logic                        res_valid_q;
	logic                        res_dvalid_q;
	logic                        res_last_q;
	logic [ssr_pkg::MATCH_W-1:0] res_mc_q;

	logic [ssr_pkg::LEN_W-1:0]  plen;
	logic [ssr_pkg::LEN_W-1:0]  rlen;
	logic                       in_acc;
	logic                       pop;
	logic                       full;
	logic                       hit;
	logic [ssr_pkg::MATCH_W-1:0] mc_next;
	logic                       src_rep;
	ssr_pkg::job_t              job;

	logic [LEN_LIMIT-1:0][ssr_pkg::BYTE_W-1:0] cand;
	logic [LEN_LIMIT-1:0][ssr_pkg::BYTE_W-1:0] win_q;
	logic [LEN_LIMIT-1:0][ssr_pkg::BYTE_W-1:0] pat_al;
	logic [LEN_LIMIT-1:0]                      eq;
	logic [LEN_LIMIT-1:0][ssr_pkg::BYTE_W-1:0] flush_b;
	logic [LEN_LIMIT-1:0][ssr_pkg::BYTE_W-1:0] load_b;
	logic [LEN_LIMIT-1:0][ssr_pkg::BYTE_W-1:0] em_q;
	logic [LEN_LIMIT-1:0][ssr_pkg::BYTE_W-1:0] em_next;

	// effective lengths
	always_comb begin
		plen = cfg_plen_q;
		if (plen == '0) begin
			plen = ssr_pkg::LEN_W'(1);
		end
		if (plen > LIM) begin
			plen = LIM;
		end
		rlen = (cfg_rlen_q > LIM) ? LIM : cfg_rlen_q;
	end

	// handshake: take a request when the emit chain is empty or empties this cycle
	assign pop      = (em_job_q.cnt != '0) && (!res_valid_q || !res_stall);
	assign in_stall = !((em_job_q.cnt == '0) ||
		((em_job_q.cnt == ssr_pkg::CNT_W'(1)) && pop));
	assign in_acc   = in_valid && !in_stall;

	// candidate bytes, newest first; pattern aligned to the same order
	always_comb begin
		cand[0] = in_byte;
		for (int j = 1; j < LEN_LIMIT; j++) begin
			cand[j] = win_q[j-1];
		end
		for (int j = 0; j < LEN_LIMIT; j++) begin
			pat_al[j] = '0;
			for (int k = 0; k < LEN_LIMIT; k++) begin
				if (ssr_pkg::LEN_W'(k + j + 1) == plen) begin
					pat_al[j] = cfg_pat_q[k];
				end
			end
		end
	end

	// window chain
	for (genvar j = 0; j < LEN_LIMIT; j++) begin : g_win
		ssr_win_cell u_cell (
			.clk      (clk),
			.shift    (in_acc),
			.d        (cand[j]),
			.pat_byte (pat_al[j]),
			.q        (win_q[j]),
			.eq       (eq[j])
		);
	end

	// match detect and job build
	always_comb begin
		full = (win_fill_q == plen - ssr_pkg::LEN_W'(1));
		hit  = full;
		for (int j = 0; j < LEN_LIMIT; j++) begin
			if ((ssr_pkg::LEN_W'(j) < plen) && !eq[j]) begin
				hit = 1'b0;
			end
		end
		mc_next = matches_q;
		if (hit && (matches_q != '1)) begin
			mc_next = matches_q + ssr_pkg::MATCH_W'(1);
		end
		// oldest byte first
		for (int i = 0; i < LEN_LIMIT; i++) begin
			flush_b[i] = '0;
			for (int j = 0; j < LEN_LIMIT; j++) begin
				if (win_fill_q == ssr_pkg::LEN_W'(i + j)) begin
					flush_b[i] = cand[j];
				end
			end
		end
		job.last   = in_last;
		job.mc     = mc_next;
		job.marker = 1'b0;
		src_rep    = 1'b0;
		priority if (hit) begin
			src_rep = 1'b1;
			job.cnt = ssr_pkg::CNT_W'(rlen);
			if ((rlen == '0) && in_last) begin
				job.marker = 1'b1;
				job.cnt    = ssr_pkg::CNT_W'(1);
			end
		end else if (in_last) begin
			job.cnt = ssr_pkg::CNT_W'(win_fill_q + ssr_pkg::LEN_W'(1));
		end else if (full) begin
			job.cnt = ssr_pkg::CNT_W'(1);
		end else begin
			job.cnt = '0;
		end
		for (int i = 0; i < LEN_LIMIT; i++) begin
			load_b[i] = src_rep ? cfg_rep_q[i] : flush_b[i];
			em_next[i] = (i + 1 < LEN_LIMIT) ? em_q[(i + 1) % LEN_LIMIT] : '0;
		end
	end

	// emit chain
	for (genvar i = 0; i < LEN_LIMIT; i++) begin : g_emit
		ssr_emit_cell u_cell (
			.clk        (clk),
			.load       (in_acc),
			.load_byte  (load_b[i]),
			.shift      (pop),
			.shift_byte (em_next[i]),
			.q          (em_q[i])
		);
	end

	// configuration, window fill and match counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_pat_q  <= '0;
			cfg_rep_q  <= '0;
			cfg_plen_q <= ssr_pkg::LEN_W'(1);
			cfg_rlen_q <= '0;
			win_fill_q <= '0;
			matches_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ssr_pkg::REG_PATTERN: begin
					cfg_pat_q <= cfg_data;
				end
				ssr_pkg::REG_PAT_LEN: begin
					cfg_plen_q <= cfg_data[ssr_pkg::LEN_W-1:0];
					win_fill_q <= '0;
				end
				ssr_pkg::REG_REPLACE: begin
					cfg_rep_q <= cfg_data;
				end
				ssr_pkg::REG_REP_LEN: begin
					cfg_rlen_q <= cfg_data[ssr_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (in_acc) begin
			matches_q <= in_last ? '0 : mc_next;
			priority if (hit || in_last) begin
				win_fill_q <= '0;
			end else if (!full) begin
				win_fill_q <= win_fill_q + ssr_pkg::LEN_W'(1);
			end
		end
	end

	// job counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_job_q <= '0;
		end else if (in_acc) begin
			em_job_q <= job;
		end else if (pop) begin
			em_job_q.cnt <= em_job_q.cnt - ssr_pkg::CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_byte_q   <= em_job_q.marker ? '0 : em_q[0];
			res_dvalid_q <= !em_job_q.marker;
			res_last_q   <= em_job_q.last && (em_job_q.cnt == ssr_pkg::CNT_W'(1));
			res_mc_q     <= em_job_q.mc;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_byte    = res_byte_q;
	assign out_valid   = res_dvalid_q;
	assign out_last    = res_last_q;
	assign match_count = res_mc_q;

`ifndef SYNTHESIS
	// window never holds a full pattern
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_fill_q < plen)
		else $error("window fill reached pattern length");

	// a bare end marker is always the final result
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_dvalid_q) |-> res_last_q)
		else $error("end marker without last flag");

	// end of stream clears window and counter
	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_last && !cfg_write) |=> (win_fill_q == '0 && matches_q == '0))
		else $error("stream state not cleared after last request");

	// a pop always fills the output register
	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> res_valid_q)
		else $error("popped result lost");
`endif

endmodule
